// ----- design/temperature_to_digit_display_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the temperature display block
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_TO_DIGIT_DISPLAY_ASSERT_SVH
`define TEMPERATURE_TO_DIGIT_DISPLAY_ASSERT_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge out of reset
`define TDD_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Condition in one cycle implies a condition in the next
`define TDD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define TDD_ASSERT_HOLD(label, cond)
`define TDD_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ----- design/tdd_pkg.sv -----
// ----------------------------------------------------------------------------
// tdd_pkg
// Shared types, constants and helper functions of the temperature display.
// ----------------------------------------------------------------------------
`default_nettype none

package tdd_pkg;

  // Display write sequence
  localparam int NUM_WRITES = 8;
  localparam int K_W        = $clog2(NUM_WRITES);
  localparam int POINT_IDX  = 1;   // position 2, zero based

  // Code-B values
  localparam logic [7:0] CODE_MINUS = 8'h0A;
  localparam logic [7:0] CODE_BLANK = 8'h0F;
  localparam logic [7:0] CODE_POINT = 8'h80;

  // Decimal digits of the rounded number: tenths plus four of the whole part
  localparam int NUM_DIGITS = 5;
  localparam int BCD_W      = 16;
  localparam int WHOLE_W    = 12;
  localparam int HALF_W     = WHOLE_W / 2;
  localparam int ND_W       = 3;

  // Front to back queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified temperature, ready for display
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;      // index 0 is the tenths digit
    logic [ND_W-1:0]            num_digits;  // digit positions used, 2..5
    logic                       neg;
  } tdd_entry_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic full;
    logic not_empty;
  } tdd_q_stat_t;

  // Tenths digit from sixteenths: round to thousandths, then to tenths
  function automatic logic [3:0] round_frac(input logic [3:0] f);
    logic [3:0] r;
    case (f)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd1;
      4'd2:    r = 4'd1;
      4'd3:    r = 4'd2;
      4'd4:    r = 4'd3;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd4;
      4'd7:    r = 4'd4;
      4'd8:    r = 4'd5;
      4'd9:    r = 4'd6;
      4'd10:   r = 4'd6;
      4'd11:   r = 4'd7;
      4'd12:   r = 4'd8;
      4'd13:   r = 4'd8;
      4'd14:   r = 4'd9;
      4'd15:   r = 4'd9;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // One double-dabble step: correct each nibble, then shift in a bit
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_W / 4; i++) begin
      if (adj[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

`default_nettype wire

// ----- design/tdd_front.sv -----
// ----------------------------------------------------------------------------
// tdd_front
// Accepts raw temperatures, takes the magnitude, rounds to tenths and
// converts the whole part to decimal over two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tdd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          in_temp_high,
  input  wire logic [7:0]          in_temp_low,
  input  wire tdd_pkg::tdd_q_stat_t q_stat,
  output logic                     q_push,
  output tdd_pkg::tdd_entry_t      q_entry
);

  logic        s1_v_r, s1_v_nxt;
  logic        s2_v_r, s2_v_nxt;
  logic        s1_ready, s2_ready;

  logic [15:0] raw;
  logic [15:0] mag;

  logic [tdd_pkg::WHOLE_W-1:0] s1_whole_r;
  logic [3:0]                  s1_tenth_r;
  logic                        s1_neg_r;

  logic [tdd_pkg::BCD_W-1:0]   s1_bcd;
  logic [tdd_pkg::BCD_W-1:0]   s2_bcd_r;
  logic [tdd_pkg::HALF_W-1:0]  s2_rest_r;
  logic [3:0]                  s2_tenth_r;
  logic                        s2_neg_r;
  logic [tdd_pkg::BCD_W-1:0]   s2_bcd;

  // Handshake through the two stages
  assign q_push   = s2_v_r && !q_stat.full;
  assign s2_ready = !s2_v_r || !q_stat.full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    s1_v_nxt = s1_ready ? in_valid : s1_v_r;
    s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Magnitude; the most negative word maps onto itself as 32768
  assign raw = {in_temp_high, in_temp_low};
  assign mag = raw[15] ? (~raw + 16'd1) : raw;

  // Stage 1: whole part, tenths digit and sign
  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_whole_r <= mag[15:4];
      s1_tenth_r <= tdd_pkg::round_frac(mag[3:0]);
      s1_neg_r   <= raw[15];
    end
  end

  // Upper half of the whole part into BCD
  always_comb begin
    s1_bcd = '0;
    for (int i = 0; i < tdd_pkg::HALF_W; i++) begin
      s1_bcd = tdd_pkg::dd_step(s1_bcd, s1_whole_r[tdd_pkg::WHOLE_W-1-i]);
    end
  end

  // Stage 2: partial BCD and the bits still to shift in
  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      s2_bcd_r   <= s1_bcd;
      s2_rest_r  <= s1_whole_r[tdd_pkg::HALF_W-1:0];
      s2_tenth_r <= s1_tenth_r;
      s2_neg_r   <= s1_neg_r;
    end
  end

  // Lower half into BCD, then classify the digit count
  always_comb begin
    s2_bcd = s2_bcd_r;
    for (int i = 0; i < tdd_pkg::HALF_W; i++) begin
      s2_bcd = tdd_pkg::dd_step(s2_bcd, s2_rest_r[tdd_pkg::HALF_W-1-i]);
    end
  end

  always_comb begin
    q_entry.digits = {s2_bcd, s2_tenth_r};
    q_entry.neg    = s2_neg_r;
    if (s2_bcd[15:12] != 4'd0) begin
      q_entry.num_digits = tdd_pkg::ND_W'(5);
    end else if (s2_bcd[11:8] != 4'd0) begin
      q_entry.num_digits = tdd_pkg::ND_W'(4);
    end else if (s2_bcd[7:4] != 4'd0) begin
      q_entry.num_digits = tdd_pkg::ND_W'(3);
    end else begin
      q_entry.num_digits = tdd_pkg::ND_W'(2);
    end
  end

endmodule

`default_nettype wire

// ----- design/tdd_queue.sv -----
// ----------------------------------------------------------------------------
// tdd_queue
// Short queue of classified temperatures between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tdd_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire tdd_pkg::tdd_entry_t push_entry,
  input  wire logic                pop,
  output tdd_pkg::tdd_q_stat_t     stat,
  output tdd_pkg::tdd_entry_t      head
);

  `include "temperature_to_digit_display_assert.svh"

  tdd_pkg::tdd_entry_t          slot_r [tdd_pkg::Q_DEPTH];
  logic [tdd_pkg::Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tdd_pkg::Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tdd_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  assign stat.full      = (cnt_r == tdd_pkg::Q_CNT_W'(tdd_pkg::Q_DEPTH));
  assign stat.not_empty = (cnt_r != '0);
  assign head           = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  `TDD_ASSERT_HOLD(a_no_push_full, !(push && stat.full))
  `TDD_ASSERT_HOLD(a_no_pop_empty, !(pop && !stat.not_empty))
  `TDD_ASSERT_NEXT(a_push_fills, push && !pop, cnt_r != '0)

endmodule

`default_nettype wire

// ----- design/tdd_back.sv -----
// ----------------------------------------------------------------------------
// tdd_back
// Walks the eight digit positions of the head temperature, one display
// write per cycle while the output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module tdd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tdd_pkg::tdd_q_stat_t q_stat,
  input  wire tdd_pkg::tdd_entry_t head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [3:0]               out_digit_position,
  output logic [7:0]               out_digit_code,
  output logic                     out_last_write
);

  `include "temperature_to_digit_display_assert.svh"

  logic                    out_valid_r, out_valid_nxt;
  logic [tdd_pkg::K_W-1:0] k_r, k_nxt;
  logic [3:0]              out_digit_position_r;
  logic [7:0]              out_digit_code_r;
  logic                    out_last_write_r;

  logic                    load;
  logic                    is_last;
  logic [3:0]              digit;
  logic [7:0]              code;

  assign load    = q_stat.not_empty && (!out_valid_r || !out_stall);
  assign is_last = (k_r == tdd_pkg::K_W'(tdd_pkg::NUM_WRITES - 1));
  assign q_pop   = load && is_last;

  // Pick the digit for this position
  always_comb begin
    case (k_r)
      3'd0:    digit = head.digits[0];
      3'd1:    digit = head.digits[1];
      3'd2:    digit = head.digits[2];
      3'd3:    digit = head.digits[3];
      3'd4:    digit = head.digits[4];
      default: digit = 4'd0;
    endcase
  end

  // Digit, then minus sign if negative, then blanks
  always_comb begin
    if (k_r < head.num_digits) begin
      code = {4'd0, digit};
      if (k_r == tdd_pkg::K_W'(tdd_pkg::POINT_IDX)) begin
        code = code | tdd_pkg::CODE_POINT;
      end
    end else if (k_r == head.num_digits && head.neg) begin
      code = tdd_pkg::CODE_MINUS;
    end else begin
      code = tdd_pkg::CODE_BLANK;
    end
  end

  // Advance the position counter and output valid
  always_comb begin
    k_nxt         = load ? k_r + 1'b1 : k_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_digit_position_r <= {1'b0, k_r} + 4'd1;
      out_digit_code_r     <= code;
      out_last_write_r     <= is_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_position = out_digit_position_r;
  assign out_digit_code     = out_digit_code_r;
  assign out_last_write     = out_last_write_r;

  `TDD_ASSERT_HOLD(a_point_on_two, !(out_valid_r && out_digit_position_r == 4'd2) || out_digit_code_r[7])
  `TDD_ASSERT_HOLD(a_last_on_eight, !(out_valid_r && out_last_write_r) || out_digit_position_r == 4'd8)
  `TDD_ASSERT_HOLD(a_ndig_range, !(load && k_r == '0) || (head.num_digits >= 3'd2 && head.num_digits <= 3'd5))

endmodule

`default_nettype wire

// ----- design/temperature_to_digit_display.sv -----
// Path: a temperature passes the stage 1 and stage 2 registers and a queue slot
// before its first digit write is loaded into the single output register that
// the back end fills, one write per cycle while out_stall is low; the front takes
// a word per cycle until its two stages and the 2-deep queue are full.
// Reset: synchronous, active low; clears stage valids, queue and write counter.
// ----------------------------------------------------------------------------
// temperature_to_digit_display
// Raw two's-complement temperature to eight code-B digit register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_to_digit_display (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_temp_high,
  input  wire logic [7:0] in_temp_low,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_digit_position,
  output logic [7:0]      out_digit_code,
  output logic            out_last_write
);

  tdd_pkg::tdd_q_stat_t q_stat;
  tdd_pkg::tdd_entry_t  q_entry;
  tdd_pkg::tdd_entry_t  q_head;
  logic                 q_push;
  logic                 q_pop;

  // Accept and classify
  tdd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_temp_high (in_temp_high),
    .in_temp_low  (in_temp_low),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  // Decouple front from back
  tdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .stat       (q_stat),
    .head       (q_head)
  );

  // Emit display writes
  tdd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_stat             (q_stat),
    .head               (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_digit_code     (out_digit_code),
    .out_last_write     (out_last_write)
  );

endmodule

`default_nettype wire

// ----- test/temperature_display_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// temperature_display_checker
// Watches both channels of the temperature display block. Every accepted
// temperature word is turned into its eight expected digit writes. Each
// accepted digit write is then compared field by field with the oldest one
// still due.
// ----------------------------------------------------------------------------

module temperature_display_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_temp_high,
  input  logic [7:0] in_temp_low,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_digit_position,
  input  logic [7:0] out_digit_code,
  input  logic       out_last_write,
  output int         mismatch_count,
  output int         words_due
);

  // Display position that carries the decimal point
  localparam int POINT_POSITION = 2;

  typedef struct packed {
    logic [3:0] position;
    logic [7:0] code;
    logic       last;
  } digit_write_t;

  digit_write_t writes_due[$];
  digit_write_t oldest_write;

  // Round the raw temperature to tenths and queue its eight display writes
  task automatic queue_display_writes(input logic [7:0] temp_high,
                                      input logic [7:0] temp_low);
    logic [15:0]  raw;
    logic         negative;
    int unsigned  magnitude;
    int unsigned  tenths;
    int unsigned  remaining;
    int           shown_digits;
    digit_write_t digit_word;
    raw       = {temp_high, temp_low};
    negative  = raw[15];
    // the most negative value comes out as 32768 here as well
    magnitude = negative ? (32'h0001_0000 - 32'(raw)) : 32'(raw);
    tenths    = ((magnitude >> 4) * 1000 + ((magnitude & 15) * 625 + 5) / 10 + 50) / 100;
    // count digits, but always show a units digit in front of the point
    shown_digits = 0;
    remaining    = tenths;
    while (remaining != 0) begin
      shown_digits++;
      remaining = remaining / 10;
    end
    if (shown_digits < POINT_POSITION) begin
      shown_digits = POINT_POSITION;
    end
    remaining = tenths;
    for (int slot = 1; slot <= tdd_pkg::NUM_WRITES; slot++) begin
      digit_word.position = 4'(slot);
      digit_word.last     = (slot == tdd_pkg::NUM_WRITES);
      if (slot <= shown_digits) begin
        digit_word.code = 8'(remaining % 10);
        if (slot == POINT_POSITION) begin
          digit_word.code = digit_word.code | tdd_pkg::CODE_POINT;
        end
        remaining = remaining / 10;
      end else if (negative && slot == shown_digits + 1) begin
        digit_word.code = tdd_pkg::CODE_MINUS;
      end else begin
        digit_word.code = tdd_pkg::CODE_BLANK;
      end
      writes_due.push_back(digit_word);
    end
  endtask

  // Compare accepted digit writes, then queue writes for accepted temperatures
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (writes_due.size() == 0) begin
          $error("unexpected digit write: position %0d code 0x%02h last %0b",
                 out_digit_position, out_digit_code, out_last_write);
          mismatch_count++;
        end else begin
          oldest_write = writes_due.pop_front();
          if (out_digit_position !== oldest_write.position) begin
            $error("digit_position: expected %0d, got %0d",
                   oldest_write.position, out_digit_position);
            mismatch_count++;
          end
          if (out_digit_code !== oldest_write.code) begin
            $error("digit_code: expected 0x%02h, got 0x%02h",
                   oldest_write.code, out_digit_code);
            mismatch_count++;
          end
          if (out_last_write !== oldest_write.last) begin
            $error("last_write: expected %0b, got %0b",
                   oldest_write.last, out_last_write);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        queue_display_writes(in_temp_high, in_temp_low);
      end
    end
    words_due <= writes_due.size();
  end

endmodule

// ----- test/tb_temperature_to_digit_display.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temperature_to_digit_display
// Drives raw temperatures into the display block: first the edge values, then
// random words under several idle and stall mixes, with one long output
// hold-off that backs the block up. A checker beside the block predicts and
// compares every digit write; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_temperature_to_digit_display;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NUM_EDGE_TEMPS  = 22;

  // Zero, both extremes, some fraction roundings, digit-count boundaries
  localparam logic [15:0] EDGE_TEMPS [NUM_EDGE_TEMPS] = '{
    16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0003,
    16'h0008, 16'h000F, 16'hFFF8, 16'hFFF1, 16'h001F, 16'h0190,
    16'hFE6F, 16'h00FF, 16'h0640, 16'h2710, 16'h7FF0, 16'h8001,
    16'hF800, 16'h00A0, 16'hFF60, 16'h5555
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_temp_high;
  logic [7:0] in_temp_low;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_digit_position;
  logic [7:0] out_digit_code;
  logic       out_last_write;

  int mismatch_count;
  int words_due;
  int send_gap_pct;
  int stall_pct;
  int hold_off_asked;
  int hold_off_done;

  temperature_to_digit_display DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temp_high       (in_temp_high),
    .in_temp_low        (in_temp_low),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_digit_code     (out_digit_code),
    .out_last_write     (out_last_write)
  );

  temperature_display_checker display_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_temp_high       (in_temp_high),
    .in_temp_low        (in_temp_low),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_digit_code     (out_digit_code),
    .out_last_write     (out_last_write),
    .mismatch_count     (mismatch_count),
    .words_due          (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a run that hangs
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stall the output at random; serve a requested hold-off in one stretch
  initial begin : receiver
    out_stall     = 1'b0;
    hold_off_done = 0;
    forever begin
      @(posedge clk);
      if (hold_off_asked != hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done++;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Offer one temperature word after a random gap; hold it until accepted
  task automatic send_temperature(input logic [15:0] raw);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_temp_high <= raw[15:8];
    in_temp_low  <= raw[7:0];
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Half room-range readings, the rest full-range noise and extremes
  function automatic logic [15:0] random_temperature();
    logic [15:0] raw;
    case ($urandom_range(3))
      0:       raw = 16'($urandom);
      1, 2:    raw = 16'(int'($urandom_range(2880)) - 880);
      default: raw = {($urandom_range(1) != 0) ? 8'h7F : 8'h80, 8'($urandom)};
    endcase
    return raw;
  endfunction

  task automatic send_random_batch(input int count, input int gap_pct,
                                   input int stall_rate);
    send_gap_pct = gap_pct;
    stall_pct    = stall_rate;
    repeat (count) send_temperature(random_temperature());
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_temp_high   = 8'h00;
    in_temp_low    = 8'h00;
    send_gap_pct   = 0;
    stall_pct      = 0;
    hold_off_asked = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edge values back to back
    foreach (EDGE_TEMPS[i]) begin
      send_temperature(EDGE_TEMPS[i]);
    end

    // random words under each idle and stall mix
    send_random_batch(19, 0, 0);
    send_random_batch(19, 47, 0);
    send_random_batch(19, 0, 47);
    send_random_batch(19, 8, 8);

    // long output hold-off while words keep coming, so the input backs up
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_off_asked++;
    repeat (12) send_temperature(random_temperature());

    // drop valid, wait out every due write, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- temperature_to_digit_display.f -----
+incdir+design
design/tdd_pkg.sv
design/tdd_front.sv
design/tdd_queue.sv
design/tdd_back.sv
design/temperature_to_digit_display.sv
test/temperature_display_checker.sv
test/tb_temperature_to_digit_display.sv
